// File: rtl/rpnbe_pkg.sv
`default_nettype none

package rpnbe_pkg;

	localparam int STACK_DEPTH = 64;
	localparam int LVL_W       = $clog2(STACK_DEPTH + 1);
	localparam int ADDR_W      = $clog2(STACK_DEPTH);

	localparam int CHAR_W = 8;
	localparam int ROW_W  = 26;
	localparam int NV_W   = 5;
	localparam int ERR_W  = 3;

	localparam int OPQ_DEPTH  = 2;
	localparam int RESQ_DEPTH = 4;

	localparam logic [ERR_W-1:0] ERR_OK        = 3'd0;
	localparam logic [ERR_W-1:0] ERR_BAD_CHAR  = 3'd1;
	localparam logic [ERR_W-1:0] ERR_UNDERFLOW = 3'd2;
	localparam logic [ERR_W-1:0] ERR_OVERFLOW  = 3'd3;
	localparam logic [ERR_W-1:0] ERR_LETTER    = 3'd4;
	localparam logic [ERR_W-1:0] ERR_LEFTOVER  = 3'd5;

	localparam logic [1:0] KIND_PUSH = 2'd0;
	localparam logic [1:0] KIND_NOT  = 2'd1;
	localparam logic [1:0] KIND_BIN  = 2'd2;
	localparam logic [1:0] KIND_ERR  = 2'd3;

	localparam logic [2:0] OP_OR  = 3'd0;
	localparam logic [2:0] OP_AND = 3'd1;
	localparam logic [2:0] OP_XOR = 3'd2;
	localparam logic [2:0] OP_EQ  = 3'd3;
	localparam logic [2:0] OP_IMP = 3'd4;

	localparam logic [CHAR_W-1:0] CH_A    = 8'h61;
	localparam logic [CHAR_W-1:0] CH_Z    = 8'h7a;
	localparam logic [CHAR_W-1:0] CH_ZERO = 8'h30;
	localparam logic [CHAR_W-1:0] CH_ONE  = 8'h31;
	localparam logic [CHAR_W-1:0] CH_NOT  = 8'h2d;
	localparam logic [CHAR_W-1:0] CH_OR   = 8'h7c;
	localparam logic [CHAR_W-1:0] CH_AND  = 8'h26;
	localparam logic [CHAR_W-1:0] CH_XOR  = 8'h23;
	localparam logic [CHAR_W-1:0] CH_EQ   = 8'h3d;
	localparam logic [CHAR_W-1:0] CH_IMP  = 8'h3e;

	typedef struct packed {
		logic [1:0]       kind;
		logic             bit_v;
		logic [2:0]       op;
		logic [ERR_W-1:0] err;
		logic             last;
	} op_t;

	typedef struct packed {
		logic             value;
		logic             is_final;
		logic [ERR_W-1:0] error_code;
	} res_t;

	function automatic logic combine(input logic [2:0] op, input logic left,
		input logic right);
		logic r;
		case (op)
			OP_OR:   r = left | right;
			OP_AND:  r = left & right;
			OP_XOR:  r = left ^ right;
			OP_EQ:   r = ~(left ^ right);
			default: r = ~left | right;
		endcase
		return r;
	endfunction

endpackage

`default_nettype wire

// File: rtl/rpnbe_ram.sv
`default_nettype none

module rpnbe_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 64
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

`default_nettype wire

// File: rtl/rpnbe_front.sv
`default_nettype none

module rpnbe_front import rpnbe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic [NV_W-1:0]   num_vars,
	input  wire logic              token_valid,
	output logic                   token_stall,
	input  wire logic [CHAR_W-1:0] token_char,
	input  wire logic [ROW_W-1:0]  row_bits,
	input  wire logic              last_token,
	output logic                   op_valid,
	input  wire logic              op_take,
	output op_t                    op_head
);

	localparam int QAW = (OPQ_DEPTH > 1) ? $clog2(OPQ_DEPTH) : 1;
	localparam int QCW = $clog2(OPQ_DEPTH + 1);

	op_t            queue_q [OPQ_DEPTH];
	logic [QAW-1:0] wp_q, rp_q;
	logic [QCW-1:0] cnt_q;

	op_t            dec;
	logic [NV_W-1:0] idx;
	logic [NV_W-1:0] sh;
	logic [31:0]    row_ext;
	logic           accept;
	logic           pop;

	function automatic logic [QAW-1:0] ptr_inc(input logic [QAW-1:0] p);
		logic [QAW-1:0] r;
		if (p == QAW'(OPQ_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + QAW'(1);
		end
		return r;
	endfunction

	always_comb begin
		idx     = NV_W'(token_char - CH_A);
		sh      = num_vars - NV_W'(1) - idx;
		row_ext = {{(32 - ROW_W){1'b0}}, row_bits};
		dec.kind  = KIND_ERR;
		dec.bit_v = 1'b0;
		dec.op    = OP_OR;
		dec.err   = ERR_BAD_CHAR;
		dec.last  = last_token;
		if (token_char >= CH_A && token_char <= CH_Z) begin
			if (idx >= num_vars) begin
				dec.err = ERR_LETTER;
			end else begin
				dec.kind  = KIND_PUSH;
				dec.bit_v = row_ext[sh];
				dec.err   = ERR_OK;
			end
		end else begin
			unique case (token_char) inside
				CH_ZERO, CH_ONE: begin
					dec.kind  = KIND_PUSH;
					dec.bit_v = token_char[0];
					dec.err   = ERR_OK;
				end
				CH_NOT: begin
					dec.kind = KIND_NOT;
					dec.err  = ERR_OK;
				end
				CH_OR, CH_AND, CH_XOR, CH_EQ, CH_IMP: begin
					dec.kind = KIND_BIN;
					dec.err  = ERR_OK;
					unique case (token_char)
						CH_OR:   dec.op = OP_OR;
						CH_AND:  dec.op = OP_AND;
						CH_XOR:  dec.op = OP_XOR;
						CH_EQ:   dec.op = OP_EQ;
						default: dec.op = OP_IMP;
					endcase
				end
				default: begin
				end
			endcase
		end
	end

	assign token_stall = (cnt_q == QCW'(OPQ_DEPTH));
	assign accept      = token_valid && !token_stall;
	assign op_valid    = (cnt_q != '0);
	assign pop         = op_valid && op_take;
	assign op_head     = queue_q[rp_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			queue_q[wp_q] <= dec;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= '0;
			rp_q  <= '0;
			cnt_q <= '0;
		end else begin
			if (accept) begin
				wp_q <= ptr_inc(wp_q);
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			if (accept && !pop) begin
				cnt_q <= cnt_q + QCW'(1);
			end else if (pop && !accept) begin
				cnt_q <= cnt_q - QCW'(1);
			end
		end
	end

endmodule

`default_nettype wire

// File: rtl/rpnbe_back.sv
`default_nettype none

module rpnbe_back import rpnbe_pkg::*; (
	input  wire logic             clk,
	input  wire logic             arst_n,
	input  wire logic             op_valid,
	output logic                  op_take,
	input  wire op_t              op_head,
	output logic                  result_valid,
	input  wire logic             result_stall,
	output logic                  value,
	output logic                  is_final,
	output logic [ERR_W-1:0]      error_code
);

	localparam int RAW = (RESQ_DEPTH > 1) ? $clog2(RESQ_DEPTH) : 1;
	localparam int RCW = $clog2(RESQ_DEPTH + 1);
	localparam logic [LVL_W-1:0] DEPTH_L = LVL_W'(STACK_DEPTH);

	logic [LVL_W-1:0] level_q;
	logic             top_q, nxt_q;
	logic [ERR_W-1:0] row_err_q;
	logic             fwd_q, fwd_bit_q;

	res_t             resq_q [RESQ_DEPTH];
	logic [RAW-1:0]   wp_q, rp_q;
	logic [RCW-1:0]   cnt_q;

	logic             below, rd_data;
	logic             wr_en;
	logic [ADDR_W-1:0] wr_addr, rd_addr;
	logic [LVL_W-1:0] n_level, f_level;
	logic             n_top, n_nxt, r_bit;
	logic [ERR_W-1:0] note, n_err, fin_err;
	logic             r1_v;
	res_t             r1, r2;
	logic             pop;
	logic [RAW-1:0]   wp_1;
	logic [1:0]       pushes;

	function automatic logic [RAW-1:0] ptr_inc(input logic [RAW-1:0] p);
		logic [RAW-1:0] r;
		if (p == RAW'(RESQ_DEPTH - 1)) begin
			r = '0;
		end else begin
			r = p + RAW'(1);
		end
		return r;
	endfunction

	assign below   = fwd_q ? fwd_bit_q : rd_data;
	assign op_take = op_valid && (cnt_q <= RCW'(RESQ_DEPTH - 2));

	always_comb begin
		n_level = level_q;
		n_top   = top_q;
		n_nxt   = nxt_q;
		note    = ERR_OK;
		wr_en   = 1'b0;
		wr_addr = ADDR_W'(level_q - LVL_W'(2));
		r1_v    = 1'b0;
		r_bit   = combine(op_head.op, nxt_q, top_q);
		r1      = '{value: 1'b0, is_final: 1'b0, error_code: ERR_OK};
		if (op_take) begin
			unique case (op_head.kind)
				KIND_PUSH: begin
					if (level_q >= DEPTH_L) begin
						note = ERR_OVERFLOW;
					end else begin
						wr_en   = (level_q >= LVL_W'(2));
						n_nxt   = top_q;
						n_top   = op_head.bit_v;
						n_level = level_q + LVL_W'(1);
					end
				end
				KIND_NOT: begin
					r1_v = 1'b1;
					if (level_q == '0) begin
						note          = ERR_UNDERFLOW;
						r1.error_code = ERR_UNDERFLOW;
					end else begin
						n_top    = ~top_q;
						r1.value = ~top_q;
					end
				end
				KIND_BIN: begin
					r1_v = 1'b1;
					if (level_q < LVL_W'(2)) begin
						note          = ERR_UNDERFLOW;
						r1.error_code = ERR_UNDERFLOW;
					end else begin
						n_top    = r_bit;
						n_nxt    = below;
						n_level  = level_q - LVL_W'(1);
						r1.value = r_bit;
					end
				end
				default: note = op_head.err;
			endcase
		end
		n_err = (row_err_q != ERR_OK) ? row_err_q : note;
		if (n_err != ERR_OK) begin
			fin_err = n_err;
		end else if (n_level == '0) begin
			fin_err = ERR_UNDERFLOW;
		end else if (n_level > LVL_W'(1)) begin
			fin_err = ERR_LEFTOVER;
		end else begin
			fin_err = ERR_OK;
		end
		r2.value      = (fin_err == ERR_OK) ? n_top : 1'b0;
		r2.is_final   = 1'b1;
		r2.error_code = fin_err;
		f_level = (op_take && op_head.last) ? '0 : n_level;
		rd_addr = ADDR_W'(f_level - LVL_W'(3));
	end

	rpnbe_ram #(
		.WIDTH(1),
		.DEPTH(STACK_DEPTH)
	) u_stack (
		.clk  (clk),
		.we   (wr_en),
		.waddr(wr_addr),
		.wdata(nxt_q),
		.raddr(rd_addr),
		.rdata(rd_data)
	);

	assign pop          = result_valid && !result_stall;
	assign result_valid = (cnt_q != '0);
	assign value        = resq_q[rp_q].value;
	assign is_final     = resq_q[rp_q].is_final;
	assign error_code   = resq_q[rp_q].error_code;
	assign wp_1         = ptr_inc(wp_q);
	assign pushes       = op_take ? ({1'b0, r1_v} + {1'b0, op_head.last}) : 2'd0;

	always_ff @(posedge clk) begin
		top_q     <= n_top;
		nxt_q     <= n_nxt;
		fwd_bit_q <= nxt_q;
		if (op_take) begin
			if (r1_v) begin
				resq_q[wp_q] <= r1;
			end
			if (op_head.last) begin
				resq_q[r1_v ? wp_1 : wp_q] <= r2;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			level_q   <= '0;
			row_err_q <= ERR_OK;
			fwd_q     <= 1'b0;
			wp_q      <= '0;
			rp_q      <= '0;
			cnt_q     <= '0;
		end else begin
			level_q   <= f_level;
			row_err_q <= (op_take && op_head.last) ? ERR_OK : n_err;
			fwd_q     <= wr_en && (wr_addr == rd_addr);
			if (pushes == 2'd1) begin
				wp_q <= wp_1;
			end else if (pushes == 2'd2) begin
				wp_q <= ptr_inc(wp_1);
			end
			if (pop) begin
				rp_q <= ptr_inc(rp_q);
			end
			cnt_q <= cnt_q + RCW'(pushes) - RCW'(pop);
		end
	end

	a_level_bound: assert property (@(posedge clk) disable iff (!arst_n)
		level_q <= DEPTH_L)
		else $error("stack level beyond depth");

	a_row_clear: assert property (@(posedge clk) disable iff (!arst_n)
		op_take && op_head.last |=> level_q == '0 && row_err_q == ERR_OK)
		else $error("row state not cleared after last token");

	a_queue_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= RCW'(RESQ_DEPTH))
		else $error("result queue overrun");

	a_err_value: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && is_final && error_code != ERR_OK |-> !value)
		else $error("final result with error carries a value");

endmodule

`default_nettype wire

// File: rtl/rpn_boolean_evaluator.sv
// Postfix Boolean expression evaluator, one truth-table row at a time. Each
// token transfer carries one character, the row assignment and a last-token
// flag; operators emit an intermediate result and the last token also emits
// the final row result with its error code. Tokens stream at one per cycle
// unless token_stall is high: a decode front end feeds a two-entry op queue,
// and the execute stage does one push, invert or pop-and-combine per cycle
// while the result queue has room for two, keeping the top two stack entries
// in flip-flops and the rest in a single-port-write RAM whose registered read
// is prefetched for the entry below. Results leave at most one per cycle from
// a four-entry queue, so a token that yields two results (operator plus
// final) sends them in turn. num_vars is written at byte address 0 of the APB
// port and is to be changed only while no row is in progress.
`default_nettype none

module rpn_boolean_evaluator import rpnbe_pkg::*; (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              psel,
	input  wire logic              penable,
	input  wire logic              pwrite,
	input  wire logic [2:0]        paddr,
	input  wire logic [31:0]       pwdata,
	output logic      [31:0]       prdata,
	output logic                   pready,
	input  wire logic              token_valid,
	output logic                   token_stall,
	input  wire logic [CHAR_W-1:0] token_char,
	input  wire logic [ROW_W-1:0]  row_bits,
	input  wire logic              last_token,
	output logic                   result_valid,
	input  wire logic              result_stall,
	output logic                   value,
	output logic                   is_final,
	output logic [ERR_W-1:0]       error_code
);

	logic [NV_W-1:0] num_vars_q;
	logic            op_valid, op_take;
	op_t             op_head;

	assign pready = 1'b1;
	assign prdata = (paddr == 3'd0) ? {{(32 - NV_W){1'b0}}, num_vars_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			num_vars_q <= NV_W'(1);
		end else if (psel && penable && pwrite && pready && paddr == 3'd0) begin
			num_vars_q <= pwdata[NV_W-1:0];
		end
	end

	rpnbe_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.num_vars   (num_vars_q),
		.token_valid(token_valid),
		.token_stall(token_stall),
		.token_char (token_char),
		.row_bits   (row_bits),
		.last_token (last_token),
		.op_valid   (op_valid),
		.op_take    (op_take),
		.op_head    (op_head)
	);

	rpnbe_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.op_valid    (op_valid),
		.op_take     (op_take),
		.op_head     (op_head),
		.result_valid(result_valid),
		.result_stall(result_stall),
		.value       (value),
		.is_final    (is_final),
		.error_code  (error_code)
	);

endmodule

`default_nettype wire
